// File: rtl/ncs_pkg.sv
// Shared types, codes and helpers for the natural cubic spline fit and evaluate block.
`timescale 1ns / 1ps
package ncs_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int Q_W         = 32;
    localparam int SEG_W       = 8;
    localparam int SPACING_W   = 31;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TUSER_W = 2;
    localparam int DIV_NUM_W   = 37;
    localparam int DIV_DEN_W   = 35;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 8'd1;

    localparam logic [OUT_TUSER_W-1:0] STAT_SAMPLE = 2'd0;
    localparam logic [OUT_TUSER_W-1:0] STAT_FIT    = 2'd1;
    localparam logic [OUT_TUSER_W-1:0] STAT_VALUE  = 2'd2;
    localparam logic [OUT_TUSER_W-1:0] STAT_ERR    = 2'd3;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/ncs_div.sv
// Radix-2 restoring divider with sign handling and saturation to 32 bits.
`timescale 1ns / 1ps
module ncs_div
    import ncs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_div_ctl                    i_ctl,
    input  logic [DIV_NUM_W+FRAC_BITS-1:0] i_dvd,
    input  logic [DIV_DEN_W-1:0]        i_dvs,
    output logic                        o_done,
    output logic signed [Q_W-1:0]       o_quo
);
    localparam int DVD_W = DIV_NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic [DVD_W-1:0]     r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_dvs;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 q_bit;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quo  <= i_dvd;
                r_rem  <= '0;
                r_dvs  <= i_dvs;
                r_neg  <= i_ctl.neg;
            end else if (r_busy) begin
                r_rem <= rem_sub[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], q_bit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_dvs == '0) begin
            o_quo = '0;
        end else if (r_neg) begin
            if (r_quo > DVD_W'(33'h80000000)) begin
                o_quo = 32'sh80000000;
            end else begin
                o_quo = signed'(32'(~r_quo[Q_W-1:0] + 32'd1));
            end
        end else if (r_quo > DVD_W'(32'h7FFFFFFF)) begin
            o_quo = 32'sh7FFFFFFF;
        end else begin
            o_quo = signed'(r_quo[Q_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

// File: rtl/natural_cubic_spline_fit_eval.sv
// Top level: sample store, spline fit sequencer and evaluator for equidistant samples.
//
// Input stream (s_axis): tuser is the opcode, 0 loads a sample and 1 evaluates.
// tdata holds sample_y, segment and query_x; tlast marks the final sample of a set.
// Output stream (m_axis): tdata carries curve_value and tuser the status code.
// Configuration channel (i_cfg_*): index 0 is x_origin, index 1 is sample_spacing.
// The block works on one item at a time; s_axis_tready is high only while the
// sequencer is idle and the output register is empty.
// A load without tlast fills the output register at the accepting edge, so its
// result is offered in the next cycle; a new load is accepted only once that
// result has been taken. A load with tlast runs the fit: h/6 by a reciprocal
// multiply, then three or four divides per interior point in the forward sweep,
// a read, multiply and write step per point backward, and one divide per point
// for the segment coefficients. Each divide runs on the shared serial divider,
// which sets the fit time. An evaluation ends in one divide by 6h on that divider.
// Reset clears the point count, the fit flag and the output register and sets
// the registers to x_origin 0 and spacing 1.0; the stores keep old contents.
// When the receiver stalls, the result waits in the output register and no new
// item is accepted until it has been taken.
`timescale 1ns / 1ps
module natural_cubic_spline_fit_eval
    import ncs_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // sample_y [31:0], segment [39:32], query_x [71:40]
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                    s_axis_tlast,
    // opcode [0]
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // curve_value [31:0]
    output logic [Q_W-1:0]          m_axis_tdata,
    // status [1:0]
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [Q_W-1:0]          i_cfg_data
);
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int PCW   = $clog2(MAX_POINTS + 1);
    localparam int DVD_W = DIV_NUM_W + FRAC_BITS;
    localparam logic signed [Q_W-1:0] QTWO  = 32'(2) << FRAC_BITS;
    localparam logic signed [Q_W-1:0] QHALF = 32'(1) << (FRAC_BITS - 1);
    localparam logic signed [63:0]    MRND  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic [31:0]           RECIP6 = 32'hAAAAAAAB;

    typedef enum logic [27:0] {
        S_IDLE   = 28'd1 << 0,
        S_F_H6   = 28'd1 << 1,
        S_F_Z0   = 28'd1 << 2,
        S_F_Z1   = 28'd1 << 3,
        S_FW_R0  = 28'd1 << 4,
        S_FW_R1  = 28'd1 << 5,
        S_FW_R2  = 28'd1 << 6,
        S_FW_D2  = 28'd1 << 7,
        S_FW_T   = 28'd1 << 8,
        S_FW_RHS = 28'd1 << 9,
        S_FW_G   = 28'd1 << 10,
        S_FW_BET = 28'd1 << 11,
        S_FW_TMP = 28'd1 << 12,
        S_FW_M   = 28'd1 << 13,
        S_BS_R   = 28'd1 << 14,
        S_BS_MUL = 28'd1 << 15,
        S_BS_W   = 28'd1 << 16,
        S_C_R    = 28'd1 << 17,
        S_C_D    = 28'd1 << 18,
        S_C_W    = 28'd1 << 19,
        S_E_R0   = 28'd1 << 20,
        S_E_R1   = 28'd1 << 21,
        S_E_DX   = 28'd1 << 22,
        S_E_C1   = 28'd1 << 23,
        S_E_C2   = 28'd1 << 24,
        S_E_P    = 28'd1 << 25,
        S_E_L    = 28'd1 << 26,
        S_E_W    = 28'd1 << 27
    } t_state;

    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        if (p < 0) begin
            p = p + MRND;
        end
        p = p >>> FRAC_BITS;
        return sat32(p);
    endfunction

    t_state r_state, n_state;

    logic [PCW-1:0]             r_pc;
    logic                       r_fit;
    logic [PCW-1:0]             r_j;
    logic signed [Q_W-1:0]      r_xo;
    logic [SPACING_W-1:0]       r_sp;
    logic                       r_ovalid;
    logic [Q_W-1:0]             r_odata;
    logic [OUT_TUSER_W-1:0]     r_ostat;

    logic signed [Q_W-1:0]      r_y0, r_y1, r_rhs, r_bet, r_mprev, r_acc, r_h6;
    logic signed [Q_W-1:0]      r_m0, r_m1, r_ca, r_cb, r_dx1, r_dx2;
    logic signed [Q_W-1:0]      r_c1, r_c2, r_l1, r_l2, r_qx;
    logic signed [40:0]         r_xj;
    logic [SEG_W-1:0]           r_seg;

    logic signed [Q_W-1:0]      r_ymem [MAX_POINTS];
    logic signed [Q_W-1:0]      r_mmem [MAX_POINTS];
    logic signed [Q_W-1:0]      r_gmem [MAX_POINTS];
    logic signed [Q_W-1:0]      r_amem [MAX_POINTS];
    logic signed [Q_W-1:0]      r_bmem [MAX_POINTS];
    logic signed [Q_W-1:0]      r_yq, r_mq, r_gq, r_aq, r_bq;

    logic                       y_we, m_we, g_we, a_we, b_we;
    logic [IW-1:0]              y_wa, m_wa, g_wa, a_wa, b_wa;
    logic [IW-1:0]              y_ra, m_ra, g_ra, ab_ra;
    logic signed [Q_W-1:0]      m_wd, g_wd;

    t_div_ctl                   div_ctl;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic signed [DIV_DEN_W:0]  div_den;
    logic [DIV_NUM_W-1:0]       div_mag;
    logic [DVD_W-1:0]           div_dvd;
    logic [DIV_DEN_W-1:0]       div_dvs;
    logic                       div_done;
    logic signed [Q_W-1:0]      div_quo;

    logic                       res_fire;
    logic [Q_W-1:0]             res_val;
    logic [OUT_TUSER_W-1:0]     res_stat;

    logic                       in_fire;
    logic                       in_op;
    logic                       in_last;
    logic signed [Q_W-1:0]      in_y, in_qx;
    logic [SEG_W-1:0]           in_seg;
    logic [PCW-1:0]             pc_eff, pc_nxt;
    logic                       ld_full, ev_bad;

    logic [IW-1:0]              jidx, segidx, seg1idx;
    logic [SPACING_W-1:0]       h_u;
    logic signed [Q_W-1:0]      h_s;
    logic signed [DIV_DEN_W:0]  h6x;
    logic [63:0]                h6_prod;
    logic signed [Q_W-1:0]      h6_w;
    logic [38:0]                segh;
    logic signed [DIV_NUM_W-1:0] d2_w, t3_w;
    logic signed [Q_W-1:0]      tmp_w, bs_val, c_val, cub_w, lin_w, res_w;

    assign in_op   = s_axis_tuser;
    assign in_last = s_axis_tlast;
    assign in_y    = signed'(s_axis_tdata[31:0]);
    assign in_seg  = s_axis_tdata[39:32];
    assign in_qx   = signed'(s_axis_tdata[71:40]);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;

    assign pc_eff  = r_fit ? '0 : r_pc;
    assign pc_nxt  = pc_eff + PCW'(1);
    assign ld_full = pc_eff >= PCW'(MAX_POINTS);
    assign ev_bad  = !r_fit || (r_pc < PCW'(2)) || ((32'(in_seg) + 32'd1) >= 32'(r_pc));

    assign jidx    = r_j[IW-1:0];
    assign segidx  = IW'(r_seg);
    assign seg1idx = IW'(9'(r_seg) + 9'd1);

    assign h_u  = (r_sp == '0) ? SPACING_W'(1) : r_sp;
    assign h_s  = signed'({1'b0, h_u});
    assign h6x  = ((DIV_DEN_W+1)'(h_s) <<< 2) + ((DIV_DEN_W+1)'(h_s) <<< 1);
    assign segh = 39'(r_seg) * 39'(h_u);

    // Truncating h/6 as a reciprocal multiply, exact for any h below 2^32.
    assign h6_prod = 64'(h_u) * 64'(RECIP6);
    assign h6_w    = signed'(32'(h6_prod >> 34));

    assign d2_w   = DIV_NUM_W'(r_yq) - (DIV_NUM_W'(r_y1) <<< 1) + DIV_NUM_W'(r_y0);
    assign t3_w   = (DIV_NUM_W'(div_quo) <<< 1) + DIV_NUM_W'(div_quo);
    assign tmp_w  = sat32(64'(r_rhs) - 64'(r_acc));
    assign bs_val = sat32(64'(r_y0) - 64'(r_acc));
    assign c_val  = sat32(64'(div_quo) - 64'(r_acc));
    assign cub_w  = sat32(64'(r_c1) + 64'(r_c2));
    assign lin_w  = sat32(64'(r_l1) + 64'(r_l2));
    assign res_w  = sat32(64'(div_quo) + 64'(lin_w));

    assign div_mag = (div_num < 0) ? DIV_NUM_W'(-div_num) : DIV_NUM_W'(div_num);
    assign div_dvd = DVD_W'(div_mag) << FRAC_BITS;
    assign div_dvs = (div_den <= 0) ? '0 : div_den[DIV_DEN_W-1:0];

    always_comb begin
        n_state       = r_state;
        y_we          = 1'b0;
        y_wa          = pc_eff[IW-1:0];
        y_ra          = jidx;
        m_we          = 1'b0;
        m_wa          = jidx;
        m_wd          = div_quo;
        m_ra          = jidx;
        g_we          = 1'b0;
        g_wa          = jidx;
        g_wd          = div_quo;
        g_ra          = IW'(r_j + PCW'(1));
        a_we          = 1'b0;
        b_we          = 1'b0;
        a_wa          = jidx;
        b_wa          = IW'(r_j - PCW'(1));
        ab_ra         = jidx;
        div_ctl.start = 1'b0;
        div_num       = '0;
        div_den       = (DIV_DEN_W+1)'(h_s);
        res_fire      = 1'b0;
        res_val       = '0;
        res_stat      = STAT_SAMPLE;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_LOAD) begin
                        if (ld_full) begin
                            res_fire = 1'b1;
                            res_stat = STAT_ERR;
                        end else begin
                            y_we = 1'b1;
                            if (in_last && (pc_nxt >= PCW'(2))) begin
                                n_state = S_F_H6;
                            end else begin
                                res_fire = 1'b1;
                                res_stat = in_last ? STAT_ERR : STAT_SAMPLE;
                            end
                        end
                    end else if (ev_bad) begin
                        res_fire = 1'b1;
                        res_stat = STAT_ERR;
                    end else begin
                        n_state = S_E_R0;
                    end
                end
            end
            S_F_H6: begin
                n_state = S_F_Z0;
            end
            S_F_Z0: begin
                m_we    = 1'b1;
                m_wa    = '0;
                m_wd    = '0;
                n_state = S_F_Z1;
            end
            S_F_Z1: begin
                m_we    = 1'b1;
                m_wa    = IW'(r_pc - PCW'(1));
                m_wd    = '0;
                n_state = (r_pc >= PCW'(3)) ? S_FW_R0 : S_C_R;
            end
            S_FW_R0: begin
                y_ra    = IW'(r_j - PCW'(1));
                n_state = S_FW_R1;
            end
            S_FW_R1: begin
                y_ra    = jidx;
                n_state = S_FW_R2;
            end
            S_FW_R2: begin
                y_ra    = IW'(r_j + PCW'(1));
                n_state = S_FW_D2;
            end
            S_FW_D2: begin
                div_ctl.start = 1'b1;
                div_num       = d2_w;
                n_state       = S_FW_T;
            end
            S_FW_T: begin
                if (div_done) begin
                    div_ctl.start = 1'b1;
                    div_num       = t3_w;
                    n_state       = S_FW_RHS;
                end
            end
            S_FW_RHS: begin
                if (div_done) begin
                    div_ctl.start = 1'b1;
                    if (r_j == PCW'(1)) begin
                        div_num = DIV_NUM_W'(div_quo);
                        div_den = (DIV_DEN_W+1)'(QTWO);
                        g_we    = 1'b1;
                        g_wd    = '0;
                        n_state = S_FW_M;
                    end else begin
                        div_num = DIV_NUM_W'(QHALF);
                        div_den = (DIV_DEN_W+1)'(r_bet);
                        n_state = S_FW_G;
                    end
                end
            end
            S_FW_G: begin
                if (div_done) begin
                    g_we    = 1'b1;
                    n_state = S_FW_BET;
                end
            end
            S_FW_BET: begin
                n_state = S_FW_TMP;
            end
            S_FW_TMP: begin
                div_ctl.start = 1'b1;
                div_num       = DIV_NUM_W'(tmp_w);
                div_den       = (DIV_DEN_W+1)'(r_bet);
                n_state       = S_FW_M;
            end
            S_FW_M: begin
                if (div_done) begin
                    m_we = 1'b1;
                    if ((r_j + PCW'(2)) == r_pc) begin
                        n_state = (r_pc >= PCW'(4)) ? S_BS_R : S_C_R;
                    end else begin
                        n_state = S_FW_R0;
                    end
                end
            end
            S_BS_R: begin
                n_state = S_BS_MUL;
            end
            S_BS_MUL: begin
                n_state = S_BS_W;
            end
            S_BS_W: begin
                m_we    = 1'b1;
                m_wd    = bs_val;
                n_state = (r_j == PCW'(1)) ? S_C_R : S_BS_R;
            end
            S_C_R: begin
                n_state = S_C_D;
            end
            S_C_D: begin
                div_ctl.start = 1'b1;
                div_num       = DIV_NUM_W'(r_yq);
                n_state       = S_C_W;
            end
            S_C_W: begin
                if (div_done) begin
                    a_we = (r_j != (r_pc - PCW'(1)));
                    b_we = (r_j != '0);
                    if (r_j == (r_pc - PCW'(1))) begin
                        res_fire = 1'b1;
                        res_stat = STAT_FIT;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_C_R;
                    end
                end
            end
            S_E_R0: begin
                m_ra    = segidx;
                ab_ra   = segidx;
                n_state = S_E_R1;
            end
            S_E_R1: begin
                m_ra    = seg1idx;
                n_state = S_E_DX;
            end
            S_E_DX: begin
                n_state = S_E_C1;
            end
            S_E_C1: begin
                n_state = S_E_C2;
            end
            S_E_C2: begin
                n_state = S_E_P;
            end
            S_E_P: begin
                n_state = S_E_L;
            end
            S_E_L: begin
                div_ctl.start = 1'b1;
                div_num       = DIV_NUM_W'(cub_w);
                div_den       = h6x;
                n_state       = S_E_W;
            end
            S_E_W: begin
                if (div_done) begin
                    res_fire = 1'b1;
                    res_stat = STAT_VALUE;
                    res_val  = res_w;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        div_ctl.neg = div_num < 0;
    end

    always_ff @(posedge i_clk) begin
        if (y_we) begin
            r_ymem[y_wa] <= in_y;
        end
        r_yq <= r_ymem[y_ra];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mmem[m_wa] <= m_wd;
        end
        r_mq <= r_mmem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_gmem[g_wa] <= g_wd;
        end
        r_gq <= r_gmem[g_ra];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_amem[a_wa] <= c_val;
        end
        r_aq <= r_amem[ab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[b_wa] <= c_val;
        end
        r_bq <= r_bmem[ab_ra];
    end

    ncs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_fit    <= 1'b0;
            r_ovalid <= 1'b0;
            r_xo     <= '0;
            r_sp     <= SPACING_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_X_ORIGIN) begin
                    r_xo <= signed'(i_cfg_data);
                end else if (i_cfg_index == REG_SPACING) begin
                    r_sp <= i_cfg_data[SPACING_W-1:0];
                end
            end
            if (res_fire) begin
                r_ovalid <= 1'b1;
                r_odata  <= res_val;
                r_ostat  <= res_stat;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_IDLE) && in_fire) begin
                if (in_op == OP_LOAD) begin
                    r_fit <= 1'b0;
                    if (ld_full) begin
                        r_pc <= in_last ? '0 : pc_eff;
                    end else if (in_last && (pc_nxt < PCW'(2))) begin
                        r_pc <= '0;
                    end else begin
                        r_pc <= pc_nxt;
                    end
                end
            end
            if ((r_state == S_C_W) && div_done && (r_j == (r_pc - PCW'(1)))) begin
                r_fit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_seg <= in_seg;
                r_qx  <= in_qx;
            end
            S_F_H6: begin
                r_h6 <= h6_w;
            end
            S_F_Z1: begin
                r_j <= (r_pc >= PCW'(3)) ? PCW'(1) : '0;
            end
            S_FW_R1: begin
                r_y0 <= r_yq;
            end
            S_FW_R2: begin
                r_y1 <= r_yq;
            end
            S_FW_RHS: begin
                if (div_done) begin
                    r_rhs <= div_quo;
                    if (r_j == PCW'(1)) begin
                        r_bet <= QTWO;
                    end
                end
            end
            S_FW_G: begin
                if (div_done) begin
                    r_acc <= mulq(QHALF, div_quo);
                end
            end
            S_FW_BET: begin
                r_bet <= sat32(64'(QTWO) - 64'(r_acc));
                r_acc <= mulq(QHALF, r_mprev);
            end
            S_FW_M: begin
                if (div_done) begin
                    r_mprev <= div_quo;
                    if ((r_j + PCW'(2)) == r_pc) begin
                        r_j <= (r_pc >= PCW'(4)) ? (r_pc - PCW'(3)) : '0;
                    end else begin
                        r_j <= r_j + PCW'(1);
                    end
                end
            end
            S_BS_MUL: begin
                r_acc <= mulq(r_gq, r_mprev);
                r_y0  <= r_mq;
            end
            S_BS_W: begin
                r_mprev <= bs_val;
                r_j     <= (r_j == PCW'(1)) ? '0 : (r_j - PCW'(1));
            end
            S_C_D: begin
                r_acc <= mulq(r_h6, r_mq);
            end
            S_C_W: begin
                if (div_done) begin
                    r_j <= r_j + PCW'(1);
                end
            end
            S_E_R1: begin
                r_m0 <= r_mq;
                r_ca <= r_aq;
                r_cb <= r_bq;
                r_xj <= 41'(r_xo) + signed'({2'b00, segh});
            end
            S_E_DX: begin
                r_m1  <= r_mq;
                r_dx1 <= sat32(64'(r_xj) + 64'(h_s) - 64'(r_qx));
                r_dx2 <= sat32(64'(r_qx) - 64'(r_xj));
            end
            S_E_C1: begin
                r_c1 <= mulq(r_dx1, r_dx1);
                r_c2 <= mulq(r_dx2, r_dx2);
            end
            S_E_C2: begin
                r_c1 <= mulq(r_c1, r_dx1);
                r_c2 <= mulq(r_c2, r_dx2);
            end
            S_E_P: begin
                r_c1 <= mulq(r_m0, r_c1);
                r_c2 <= mulq(r_m1, r_c2);
            end
            S_E_L: begin
                r_l1 <= mulq(r_ca, r_dx1);
                r_l2 <= mulq(r_cb, r_dx2);
            end
            default: begin
            end
        endcase
    end

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("Item accepted while the sequencer is busy.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PCW'(MAX_POINTS))
        else $error("Point count exceeds the store depth.");

    a_fit_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fit |-> (r_pc >= PCW'(2)))
        else $error("Fit flagged with fewer than two points.");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_VALUE)) |-> (m_axis_tdata == '0))
        else $error("Nonzero value on a non-value status.");

endmodule

// File: tb/sv/natural_cubic_spline_fit_eval_test.sv
// Self-checking test of the spline block: directed table, sample sets, evaluations and a checker.
`timescale 1ns / 1ps
module natural_cubic_spline_fit_eval_test;
    import ncs_pkg::*;

    localparam longint ONE_Q = 64'sd65536;
    localparam int     STORE_DEPTH = 256;
    localparam int     IDLE_LIMIT = 400000;
    localparam int     RANDOM_ITEMS = 150;
    localparam int     LONG_HOLD = 400;

    typedef struct packed {
        logic        op;
        logic [31:0] y;
        logic        last;
        logic [7:0]  seg;
        logic [31:0] qx;
    } spline_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } spline_result_t;

    typedef struct packed {
        spline_item_t   item;
        logic           typed;
        spline_result_t res;
    } table_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [Q_W-1:0]         m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [Q_W-1:0]         i_cfg_data;

    natural_cubic_spline_fit_eval dut (.*);

    // Spline state as the block should hold it.
    longint      heights [STORE_DEPTH];
    longint      curv [STORE_DEPTH];
    longint      lin_left [STORE_DEPTH];
    longint      lin_right [STORE_DEPTH];
    longint      sweep_gain [STORE_DEPTH];
    int unsigned n_points;
    bit          have_fit;
    longint      origin;
    longint      spacing_q;

    spline_result_t pending_results[$];
    int  n_mismatch = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_values = 0;
    int  n_fits = 0;
    int  n_errors = 0;
    bit  quiet = 0;
    bit  long_hold = 0;
    bit  done = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b) / ONE_Q);
    endfunction

    function automatic longint qdiv(input longint a, input longint b);
        if (b <= 0) return 0;
        return clamp32((a * ONE_Q) / b);
    endfunction

    function automatic longint step_h();
        return (spacing_q == 0) ? 1 : spacing_q;
    endfunction

    function automatic void fit_spline(input int unsigned n);
        longint h;
        longint bet;
        longint h6;
        longint d2;
        longint t;
        longint rhs;
        longint g;
        h = step_h();
        bet = 2 * ONE_Q;
        h6 = h / 6;
        curv[0] = 0;
        curv[n-1] = 0;
        sweep_gain[0] = 0;
        for (int j = 1; j + 1 < n; j++) begin
            d2 = heights[j+1] - 2 * heights[j] + heights[j-1];
            t = qdiv(d2, h);
            rhs = qdiv(3 * t, h);
            if (j == 1) begin
                sweep_gain[j] = 0;
                bet = 2 * ONE_Q;
                curv[j] = qdiv(rhs, bet);
            end else begin
                g = qdiv(ONE_Q / 2, bet);
                sweep_gain[j] = g;
                bet = clamp32(2 * ONE_Q - qmul(ONE_Q / 2, g));
                curv[j] = qdiv(clamp32(rhs - qmul(ONE_Q / 2, curv[j-1])), bet);
            end
        end
        if (n >= 4) begin
            for (int j = n - 3; j >= 1; j--) begin
                curv[j] = clamp32(curv[j] - qmul(sweep_gain[j+1], curv[j+1]));
            end
        end
        for (int j = 0; j + 1 < n; j++) begin
            lin_left[j] = clamp32(qdiv(heights[j], h) - qmul(h6, curv[j]));
            lin_right[j] = clamp32(qdiv(heights[j+1], h) - qmul(h6, curv[j+1]));
        end
    endfunction

    function automatic longint spline_value(input int unsigned seg, input longint x);
        longint h;
        longint xj;
        longint dx1;
        longint dx2;
        longint cub;
        longint lin;
        h = step_h();
        xj = origin + longint'(seg) * h;
        dx1 = clamp32(xj + h - x);
        dx2 = clamp32(x - xj);
        cub = clamp32(qmul(curv[seg], qmul(qmul(dx1, dx1), dx1))
                      + qmul(curv[seg+1], qmul(qmul(dx2, dx2), dx2)));
        lin = clamp32(qmul(lin_left[seg], dx1) + qmul(lin_right[seg], dx2));
        return clamp32(qdiv(cub, 6 * h) + lin);
    endfunction

    function automatic spline_result_t predict_result(input spline_item_t it);
        spline_result_t r;
        r.value = '0;
        if (it.op == OP_LOAD) begin
            if (have_fit) begin
                have_fit = 0;
                n_points = 0;
            end
            if (n_points >= STORE_DEPTH) begin
                r.status = STAT_ERR;
                if (it.last) n_points = 0;
            end else begin
                heights[n_points] = longint'(signed'(it.y));
                n_points++;
                r.status = STAT_SAMPLE;
                if (it.last) begin
                    if (n_points < 2) begin
                        n_points = 0;
                        r.status = STAT_ERR;
                    end else begin
                        fit_spline(n_points);
                        have_fit = 1;
                        r.status = STAT_FIT;
                    end
                end
            end
        end else if (!have_fit || n_points < 2 || it.seg + 1 >= n_points) begin
            r.status = STAT_ERR;
        end else begin
            r.value = spline_value(it.seg, longint'(signed'(it.qx)));
            r.status = STAT_VALUE;
        end
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        spline_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (m_axis_tuser == STAT_VALUE) n_values++;
            if (m_axis_tuser == STAT_FIT) n_fits++;
            if (m_axis_tuser == STAT_ERR) n_errors++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: value %h status %0d", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (want.value !== m_axis_tdata || want.status !== m_axis_tuser) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result %0d: expected value %h status %0d, got value %h status %0d",
                                 n_results, want.value, want.status, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT && !done) begin
                $display("timeout after %0d idle cycles", idle);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        m_axis_tready = 1;
        @(posedge i_rst_n);
        forever begin
            if (quiet) begin
                m_axis_tready <= 1;
                @(negedge i_clk);
            end else if (long_hold) begin
                m_axis_tready <= 0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
        end
    end

    task automatic send_item(input spline_item_t it, input bit typed, input spline_result_t typed_res);
        spline_result_t r;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {it.qx, it.seg, it.y};
        s_axis_tlast <= it.last;
        s_axis_tuser <= it.op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_result(it);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    task automatic load(input logic [31:0] y, input logic last);
        spline_item_t it;
        it = '{op: OP_LOAD, y: y, last: last, seg: 8'($urandom_range(0, 254)), qx: $urandom};
        send_item(it, 0, '0);
    endtask

    task automatic query(input logic [7:0] seg, input logic [31:0] qx);
        spline_item_t it;
        it = '{op: OP_EVAL, y: $urandom, last: 1'($urandom_range(0, 1)), seg: seg, qx: qx};
        send_item(it, 0, '0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_X_ORIGIN) origin = longint'(signed'(d));
        else if (idx == REG_SPACING) spacing_q = longint'(d[30:0]);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [31:0] random_height();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(longint'($urandom_range(0, 2 * 1048576)) - 1048576);
        endcase
    endfunction

    function automatic logic [31:0] query_in(input int unsigned seg);
        longint h;
        longint x;
        h = step_h();
        x = origin + longint'(seg) * h + longint'($urandom_range(0, 32'(clamp32(h))));
        if ($urandom_range(0, 7) == 0) x = x + (longint'($urandom_range(0, 4)) - 2) * h;
        if ($urandom_range(0, 15) == 0) return $urandom;
        return 32'(clamp32(x));
    endfunction

    table_row_t directed [24] = '{
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_LOAD, 32'h00050000, 1'b1, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_LOAD, 32'h7FFFFFFF, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'h80000000, 1'b1, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_FIT}},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h00008000}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd1, 32'h00008000}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd254, 32'h0}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_EVAL, 32'hFFFFFFFF, 1'b1, 8'd0, 32'h7FFFFFFF}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h80000000}, 1'b0, '0},
        '{'{OP_LOAD, 32'h0, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'h00030000, 1'b0, 8'hFF, 32'hFFFFFFFF}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'hFFFF0000, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'h00020000, 1'b1, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_FIT}},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h00004000}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd1, 32'h00018000}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd2, 32'h00030000}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd3, 32'h00030000}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_LOAD, 32'h00010000, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_ERR}},
        '{'{OP_LOAD, 32'h7FFFFFFF, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'h7FFFFFFF, 1'b0, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_SAMPLE}},
        '{'{OP_LOAD, 32'h80000000, 1'b1, 8'd0, 32'h0}, 1'b1, '{32'h0, STAT_FIT}},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd1, 32'h00018000}, 1'b0, '0},
        '{'{OP_EVAL, 32'h0, 1'b0, 8'd0, 32'h7FFFFFFF}, 1'b0, '0}
    };

    initial begin
        int start_items;
        int n;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        s_axis_tuser = OP_LOAD;
        i_cfg_valid = 0;
        i_cfg_index = REG_X_ORIGIN;
        i_cfg_data = '0;
        n_points = 0;
        have_fit = 0;
        origin = 0;
        spacing_q = 65536;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        foreach (directed[k]) send_item(directed[k].item, directed[k].typed, directed[k].res);

        // Extreme register settings on a short set, then the unused index and zero spacing.
        write_reg(REG_X_ORIGIN, 32'h80000000);
        write_reg(REG_SPACING, 32'hFFFFFFFF);
        for (int k = 0; k < 4; k++) load(random_height(), k == 3);
        for (int k = 0; k < 3; k++) query(8'(k), query_in(k));
        write_reg(REG_X_ORIGIN, 32'h7FFFFFFF);
        write_reg(REG_SPACING, 32'h00000001);
        for (int k = 0; k < 3; k++) query(8'(k), query_in(k));
        write_reg(8'd7, 32'h12345678);
        write_reg(REG_SPACING, 32'h0);
        for (int k = 0; k < 3; k++) query(8'(k), query_in(k));

        // A full store fits and evaluates at its last segment and at its first.
        write_reg(REG_X_ORIGIN, 32'h0);
        write_reg(REG_SPACING, 32'h00010000);
        for (int k = 0; k < STORE_DEPTH; k++) load(random_height(), k == STORE_DEPTH - 1);
        query(8'd254, query_in(254));
        query(8'd0, query_in(0));

        start_items = n_items;
        long_hold = 1;
        while (n_items - start_items < RANDOM_ITEMS) begin
            if (n_items - start_items > RANDOM_ITEMS - 60) quiet = 1;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_X_ORIGIN, $urandom);
                    1: write_reg(REG_X_ORIGIN, 32'(longint'($urandom_range(0, 2 * 655360)) - 655360));
                    default: write_reg(REG_SPACING, $urandom_range(0, 9) == 0 ? $urandom
                                                    : $urandom_range(256, 262144));
                endcase
                if ($urandom_range(0, 9) == 0) write_reg(8'($urandom_range(2, 255)), $urandom);
            end
            case ($urandom_range(0, 19))
                0: n = 1;
                1: n = $urandom_range(20, 40);
                default: n = $urandom_range(2, 10);
            endcase
            for (int k = 0; k < n; k++) begin
                load(random_height(), k == n - 1);
                if ($urandom_range(0, 15) == 0) query(8'($urandom_range(0, 254)), $urandom);
            end
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 7) == 0) begin
                    query(8'($urandom_range(0, 254)), $urandom);
                end else begin
                    int unsigned s;
                    s = (n > 1) ? $urandom_range(0, n - 2) : 0;
                    query(8'(s), query_in(s));
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        done = 1;
        $display("Ran %0d items: %0d spline fits, %0d values, %0d error replies, %0d results checked.",
                 n_items, n_fits, n_values, n_errors, n_results);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
